// ----- sv/color_fade_table_assert.svh -----
// assertion macros shared by the color fade table modules
// no dependencies; included by files that carry concurrent checks
`ifndef COLOR_FADE_TABLE_ASSERT_SVH
`define COLOR_FADE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define CFT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("color_fade_table check failed");
`define CFT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("color_fade_table forbidden condition");
`else
`define CFT_ASSERT(label, clk, rst, prop)
`define CFT_NEVER(label, clk, rst, cond)
`endif
`endif

// ----- sv/cft_pkg.sv -----
// shared types and constants of the color fade table
// no dependencies
package cft_pkg;
  localparam int SLOTS  = 12;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int DIV_STEPS = 31;
  localparam int DCNT_W = $clog2(DIV_STEPS);
  localparam int CHANNELS = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } cft_state_t;

  typedef struct packed {
    logic tick_start;
    logic load;
    logic advance;
    logic check;
    logic div_step;
    logic mul_step;
    logic emit;
  } cft_cmd_t;

  typedef struct packed {
    logic at_end;
    logic live;
    logic expired;
    logic zero_dur;
    logic div_last;
    logic mul_last;
  } cft_stat_t;
endpackage

// ----- sv/color_fade_table.sv -----
// top level of the color fade table
// depends on cft_pkg, cft_ctrl, cft_dp and color_fade_table_assert.svh
//
// a load (kind 1) writes one of the twelve slots and gives no result;
// busy stays low. a tick (kind 0) walks all slots in order and gives
// one result per live slot, each shown for exactly one cycle with
// strobe high; the receiver cannot stall, so it must take every
// transfer when strobe is high. last marks the final transfer of a
// tick; a tick with no live slot gives none. busy is high from the tick's
// transfer until the walk ends. an empty slot is only scanned; a slot
// that expires or has zero duration goes through scan, check and emit;
// an interpolated slot goes through scan, check, the bit-serial divider
// (31 steps), the shared multiplier (one channel a cycle, then one more
// step to write back the last) and emit. the walk ends with one more
// scan past the last slot.
`include "color_fade_table_assert.svh"
module color_fade_table import cft_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [3:0]         slot,
  input  logic signed [31:0] target_handle,
  input  logic [31:0]        base_color,
  input  logic [31:0]        target_color,
  input  logic signed [15:0] fade_length,
  input  logic signed [15:0] time_left,
  input  logic [14:0]        amount,
  output logic               strobe,
  output logic signed [31:0] out_handle,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  output logic               via_call,
  output logic               finished,
  output logic               last
);
  cft_cmd_t  cmd;
  cft_stat_t stat;
  logic      go;

  // a transfer is only taken while the sequencer is idle
  assign go = start && !busy;

  cft_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(go), .kind(kind),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  cft_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .slot(slot), .target_handle(target_handle), .base_color(base_color),
    .target_color(target_color), .fade_length(fade_length),
    .time_left(time_left), .amount(amount),
    .strobe(strobe), .out_handle(out_handle), .red(red), .green(green),
    .blue(blue), .alpha(alpha), .via_call(via_call),
    .finished(finished), .last(last)
  );

  // results only appear inside a tick walk
  `CFT_NEVER(a_strobe_busy, clk, rst, strobe && !busy)
  // no two results come back to back
  `CFT_ASSERT(a_strobe_gap, clk, rst, strobe |=> !strobe)
  // a tick transfer starts the walk
  `CFT_ASSERT(a_tick_busy, clk, rst, (start && !busy && !kind) |=> busy)
  // a load never starts the walk
  `CFT_ASSERT(a_load_idle, clk, rst, (start && !busy && kind) |=> !busy)
endmodule

// ----- sv/cft_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module cft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/cft_ctrl.sv -----
// sequencer of the color fade table: walks slots, runs divide and multiply
// depends on cft_pkg
module cft_ctrl import cft_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      kind,
  input  cft_stat_t stat,
  output cft_cmd_t  cmd,
  output logic      busy
);
  cft_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (start && kind) begin
          cmd.load = 1'b1;
        end else if (start) begin
          cmd.tick_start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.at_end) begin
          state_next = ST_IDLE;
        end else if (stat.live) begin
          state_next = ST_CHECK;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (stat.expired || stat.zero_dur) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.advance = 1'b1;
        state_next = ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);
endmodule

// ----- sv/cft_dp.sv -----
// datapath of the color fade table: slot storage, divider, multiplier
// depends on cft_pkg and cft_ram
module cft_dp import cft_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cft_cmd_t           cmd,
  output cft_stat_t          stat,
  input  logic [3:0]         slot,
  input  logic signed [31:0] target_handle,
  input  logic [31:0]        base_color,
  input  logic [31:0]        target_color,
  input  logic signed [15:0] fade_length,
  input  logic signed [15:0] time_left,
  input  logic [14:0]        amount,
  output logic               strobe,
  output logic signed [31:0] out_handle,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  output logic               via_call,
  output logic               finished,
  output logic               last
);
  logic [31:0]        handle [SLOTS];
  logic [SLOTS-1:0]   live;
  logic [CNT_W-1:0]   s;
  logic [SLOT_W-1:0]  idx;
  logic [14:0]        amt;
  logic [63:0]        col_rd;
  logic [31:0]        tim_rd;
  logic               load_ok;
  logic               tim_we;
  logic [SLOT_W-1:0]  tim_waddr;
  logic [31:0]        tim_wdata;
  logic signed [15:0] rem, dur, rem_new;
  logic               expired;
  logic [31:0]        hd;
  logic [3:0][7:0]    base_b, targ_b, res;
  logic               fin;
  logic               dur_neg;
  logic [16:0]        dmag;
  logic [16:0]        r;
  logic [30:0]        q;
  logic [DCNT_W-1:0]  dcnt;
  logic [17:0]        trial;
  logic               fits;
  logic [16:0]        r_nx;
  logic [30:0]        q_nx;
  logic signed [31:0] factor;
  logic [2:0]         ch;
  logic [1:0]         cur, prv;
  logic signed [8:0]  diff;
  logic signed [40:0] prod;
  logic               above;

  assign idx = s[SLOT_W-1:0];
  assign load_ok = cmd.load && (32'(slot) < SLOTS);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      live[i] = |handle[i];
    end
  end

  always_comb begin
    above = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (live[i] && (i > int'(idx))) begin
        above = 1'b1;
      end
    end
  end

  cft_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_colors (
    .clk(clk), .we(load_ok), .waddr(SLOT_W'(slot)),
    .wdata({base_color, target_color}), .raddr(idx), .rdata(col_rd)
  );

  assign rem     = tim_rd[31:16];
  assign dur     = tim_rd[15:0];
  assign expired = $signed({1'b0, amt}) >= rem;
  assign rem_new = rem - $signed({1'b0, amt});

  assign tim_we    = load_ok || (cmd.check && !expired);
  assign tim_waddr = cmd.load ? SLOT_W'(slot) : idx;
  assign tim_wdata = cmd.load ? {time_left, fade_length} : {rem_new, dur};

  cft_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_timing (
    .clk(clk), .we(tim_we), .waddr(tim_waddr),
    .wdata(tim_wdata), .raddr(idx), .rdata(tim_rd)
  );

  assign stat.at_end   = (s == CNT_W'(SLOTS));
  assign stat.live     = stat.at_end ? 1'b0 : live[idx];
  assign stat.expired  = expired;
  assign stat.zero_dur = (dur == 16'sd0);
  assign stat.div_last = (dcnt == DCNT_W'(DIV_STEPS - 1));
  assign stat.mul_last = (ch == 3'(CHANNELS));

  // one restoring step per cycle
  assign trial = {r, q[30]};
  assign fits  = (trial >= {1'b0, dmag});
  assign r_nx  = fits ? 17'(trial - {1'b0, dmag}) : trial[16:0];
  assign q_nx  = {q[29:0], fits};

  assign cur  = 2'(3 - int'(ch));
  assign prv  = 2'(4 - int'(ch));
  assign diff = $signed({1'b0, targ_b[cur]}) - $signed({1'b0, base_b[cur]});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        handle[i] <= '0;
      end
      s      <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
      if (load_ok) begin
        handle[SLOT_W'(slot)] <= target_handle;
      end
      if (cmd.tick_start) begin
        s <= '0;
      end else if (cmd.advance) begin
        s <= s + 1'b1;
      end
      if (cmd.check && expired) begin
        handle[idx] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      amt <= amount;
    end
    if (cmd.check) begin
      hd      <= handle[idx];
      base_b  <= col_rd[63:32];
      targ_b  <= col_rd[31:0];
      res     <= col_rd[63:32];
      fin     <= expired;
      dur_neg <= dur[15];
      dmag    <= dur[15] ? 17'(17'd0 - {1'b1, dur}) : {1'b0, dur};
      r       <= '0;
      q       <= {rem_new[14:0], 16'b0};
      dcnt    <= '0;
      ch      <= '0;
    end
    if (cmd.div_step) begin
      r    <= r_nx;
      q    <= q_nx;
      dcnt <= dcnt + 1'b1;
      if (stat.div_last) begin
        factor <= dur_neg ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
      end
    end
    if (cmd.mul_step) begin
      if (ch < 3'(CHANNELS)) begin
        prod <= diff * factor;
      end
      if (ch != 3'd0) begin
        res[prv] <= base_b[prv] + prod[23:16];
      end
      ch <= ch + 1'b1;
    end
    if (cmd.emit) begin
      out_handle <= hd;
      red        <= res[3];
      green      <= res[2];
      blue       <= res[1];
      alpha      <= res[0];
      via_call   <= hd[31];
      finished   <= fin;
      last       <= !above;
    end
  end
endmodule
